@@ hw/rtl/mbcd_pkg.sv @@
// Shared types and constants for the multiplexed BCD display decoder.
`default_nettype none

package mbcd_pkg;

    localparam logic [2:0] SRC_STATUS    = 3'd0;
    localparam logic [2:0] SRC_DIGIT_MAX = 3'd4;

    localparam logic [3:0] DIGIT_MAX  = 4'd9;
    localparam logic [1:0] POINT_NONE = 2'd3;

    localparam int FLAG_HV  = 0;
    localparam int FLAG_REL = 1;
    localparam int FLAG_NEG = 2;
    localparam int FLAG_POS = 3;
    localparam int FLAG_DB  = 4;
    localparam int FLAG_ONE = 5;

    typedef struct packed {
        logic [2:0] strobe_source;
        logic [3:0] digit_strobes;
        logic [3:0] code_lines;
        logic       dp_line;
        logic       hv_line;
    } mbcd_in_t;

    typedef struct packed {
        logic signed [15:0] reading_count;
        logic [1:0]         decimal_pos;
        logic [5:0]         status_flags;
        logic signed [15:0] relative_count;
        logic [1:0]         relative_decimal;
        logic               bcd_error;
    } mbcd_out_t;

endpackage

`default_nettype wire

@@ hw/rtl/mbcd_in_if.sv @@
// Request channel carrying one strobe event into the decoder.
`default_nettype none

interface mbcd_in_if;
    logic              valid;
    logic              ready;
    mbcd_pkg::mbcd_in_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/mbcd_out_if.sv @@
// Result channel carrying one decoded reading out of the decoder.
`default_nettype none

interface mbcd_out_if;
    logic               valid;
    logic               ready;
    mbcd_pkg::mbcd_out_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/multiplexed_bcd_display_decoder.sv @@
// Top level of the multiplexed 4.5-digit BCD display decoder.
// A thousands-digit strobe request passes the stage register, then the result register.
// Throughput: one request per cycle unless stalled; the result register frees the input side while it waits.
// Only a held result that is not taken stalls a later request that also makes a result.
// Reset clears all digits, flags and counts, sets all decimal positions to none (3),
// and holds ready low until the run register is set after reset is released.
`default_nettype none

module multiplexed_bcd_display_decoder (
    input  wire       clk,
    input  wire       rst_n,
    mbcd_in_if.sink   in_ch,
    mbcd_out_if.source out_ch
);

    logic                run_reg;
    logic                s_valid_reg;
    mbcd_pkg::mbcd_in_t  s_data_reg;
    logic                out_valid_reg;
    mbcd_pkg::mbcd_out_t out_data_reg;

    logic [3:0]          digit_reg [4];
    logic [3:0]          digit_next [4];
    logic [1:0]          point_pos_reg;
    logic [1:0]          point_pos_next;
    logic [5:0]          flags_reg;
    logic [5:0]          flags_next;
    logic signed [15:0]  value_count_reg;
    logic signed [15:0]  value_count_next;
    logic [1:0]          value_point_reg;
    logic [1:0]          value_point_next;
    logic signed [15:0]  rel_count_reg;
    logic signed [15:0]  rel_count_next;
    logic [1:0]          rel_point_reg;
    logic [1:0]          rel_point_next;

    logic                is_digit;
    logic                pos_hit;
    logic [1:0]          pos;
    logic                makes_result;
    logic                stage_fire;
    logic                digits_ok;
    logic [14:0]         magnitude;
    logic                negate;
    logic                bcd_error;

    always_comb
    begin
        pos_hit = 1'b1;
        pos     = 2'd0;
        priority if (s_data_reg.digit_strobes[3])
        begin
            pos = 2'd0;
        end
        else if (s_data_reg.digit_strobes[2])
        begin
            pos = 2'd1;
        end
        else if (s_data_reg.digit_strobes[1])
        begin
            pos = 2'd2;
        end
        else if (s_data_reg.digit_strobes[0])
        begin
            pos = 2'd3;
        end
        else
        begin
            pos_hit = 1'b0;
        end
    end

    assign is_digit = (s_data_reg.strobe_source != mbcd_pkg::SRC_STATUS)
                   && (s_data_reg.strobe_source <= mbcd_pkg::SRC_DIGIT_MAX)
                   && pos_hit;
    assign makes_result = is_digit && (pos == mbcd_pkg::POINT_NONE);
    assign stage_fire = s_valid_reg && (!makes_result || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = run_reg && (!s_valid_reg || stage_fire);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            digit_next[i] = digit_reg[i];
        end
        if (is_digit)
        begin
            digit_next[pos] = s_data_reg.code_lines;
        end
    end

    assign digits_ok = (digit_next[0] <= mbcd_pkg::DIGIT_MAX)
                    && (digit_next[1] <= mbcd_pkg::DIGIT_MAX)
                    && (digit_next[2] <= mbcd_pkg::DIGIT_MAX)
                    && (digit_next[3] <= mbcd_pkg::DIGIT_MAX);

    assign magnitude = 15'(flags_reg[mbcd_pkg::FLAG_ONE]) * 15'd10000
                     + 15'(digit_next[3]) * 15'd1000
                     + 15'(digit_next[2]) * 15'd100
                     + 15'(digit_next[1]) * 15'd10
                     + 15'(digit_next[0]);
    assign negate = flags_reg[mbcd_pkg::FLAG_NEG] && !flags_reg[mbcd_pkg::FLAG_POS];
    assign bcd_error = !digits_ok;

    always_comb
    begin
        point_pos_next   = point_pos_reg;
        flags_next       = flags_reg;
        value_count_next = value_count_reg;
        value_point_next = value_point_reg;
        rel_count_next   = rel_count_reg;
        rel_point_next   = rel_point_reg;
        if (s_data_reg.strobe_source == mbcd_pkg::SRC_STATUS)
        begin
            flags_next[mbcd_pkg::FLAG_HV]  = s_data_reg.hv_line;
            flags_next[mbcd_pkg::FLAG_REL] = s_data_reg.dp_line;
            flags_next[mbcd_pkg::FLAG_NEG] = s_data_reg.code_lines[3];
            flags_next[mbcd_pkg::FLAG_POS] = s_data_reg.code_lines[2];
            flags_next[mbcd_pkg::FLAG_DB]  = s_data_reg.code_lines[1];
            flags_next[mbcd_pkg::FLAG_ONE] = s_data_reg.code_lines[0];
            if (s_data_reg.dp_line)
            begin
                if (!flags_reg[mbcd_pkg::FLAG_REL])
                begin
                    rel_count_next = value_count_reg;
                    rel_point_next = value_point_reg;
                end
            end
            else
            begin
                rel_count_next = '0;
                rel_point_next = mbcd_pkg::POINT_NONE;
            end
        end
        else if (is_digit)
        begin
            if (s_data_reg.dp_line)
            begin
                point_pos_next = pos;
            end
            if (makes_result && digits_ok)
            begin
                value_count_next = negate ? -$signed({1'b0, magnitude})
                                          : $signed({1'b0, magnitude});
                value_point_next = point_pos_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg         <= 1'b0;
            s_valid_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < 4; i++)
            begin
                digit_reg[i] <= '0;
            end
            point_pos_reg   <= mbcd_pkg::POINT_NONE;
            flags_reg       <= '0;
            value_count_reg <= '0;
            value_point_reg <= mbcd_pkg::POINT_NONE;
            rel_count_reg   <= '0;
            rel_point_reg   <= mbcd_pkg::POINT_NONE;
        end
        else
        begin
            run_reg <= 1'b1;
            if (in_ch.valid && in_ch.ready)
            begin
                s_valid_reg <= 1'b1;
            end
            else if (stage_fire)
            begin
                s_valid_reg <= 1'b0;
            end
            if (stage_fire && makes_result)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (stage_fire)
            begin
                for (int i = 0; i < 4; i++)
                begin
                    digit_reg[i] <= digit_next[i];
                end
                point_pos_reg   <= point_pos_next;
                flags_reg       <= flags_next;
                value_count_reg <= value_count_next;
                value_point_reg <= value_point_next;
                rel_count_reg   <= rel_count_next;
                rel_point_reg   <= rel_point_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            s_data_reg <= in_ch.data;
        end
        if (stage_fire && makes_result)
        begin
            out_data_reg.reading_count    <= value_count_next;
            out_data_reg.decimal_pos      <= value_point_next;
            out_data_reg.status_flags     <= flags_reg;
            out_data_reg.relative_count   <= rel_count_reg;
            out_data_reg.relative_decimal <= rel_point_reg;
            out_data_reg.bcd_error        <= bcd_error;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/mbcd_checker.sv @@
// Port-level checker for the multiplexed BCD display decoder and its bind.
`default_nettype none

module mbcd_checker (
    input wire                clk,
    input wire                rst_n,
    input wire                in_valid,
    input wire                in_ready,
    input wire                out_valid,
    input wire                out_ready,
    input wire signed [15:0]  reading_count,
    input wire [5:0]          status_flags,
    input wire signed [15:0]  relative_count,
    input wire [1:0]          relative_decimal
);

    // A result that is not taken stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its count.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(reading_count))
        else $error("stalled result count changed");

    // A fresh result must follow an accepted request.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without a matching request");

    // The converted count never leaves the range of a 4.5-digit display.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (reading_count <= 16'sd19999) && (reading_count >= -16'sd19999))
        else $error("reading count out of range");

    // Without relative mode the reference is cleared.
    a_rel_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !status_flags[mbcd_pkg::FLAG_REL]
            |-> (relative_count == 16'sd0) && (relative_decimal == mbcd_pkg::POINT_NONE))
        else $error("relative reference set while relative mode is off");

endmodule

bind multiplexed_bcd_display_decoder mbcd_checker u_mbcd_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .reading_count    (out_ch.data.reading_count),
    .status_flags     (out_ch.data.status_flags),
    .relative_count   (out_ch.data.relative_count),
    .relative_decimal (out_ch.data.relative_decimal)
);

`default_nettype wire
